FILE: rtl/cpualu_pkg.sv
package cpualu_pkg;

  // Operation codes; code 31 is unused and passes operand_a and flags through
  typedef enum logic [4:0] {
    FnAdd   = 5'd0,
    FnAdc   = 5'd1,
    FnSub   = 5'd2,
    FnSbc   = 5'd3,
    FnAnd   = 5'd4,
    FnXor   = 5'd5,
    FnOr    = 5'd6,
    FnCp    = 5'd7,
    FnInc   = 5'd8,
    FnDec   = 5'd9,
    FnRlca  = 5'd10,
    FnRrca  = 5'd11,
    FnRla   = 5'd12,
    FnRra   = 5'd13,
    FnDaa   = 5'd14,
    FnCpl   = 5'd15,
    FnScf   = 5'd16,
    FnCcf   = 5'd17,
    FnRlc   = 5'd18,
    FnRrc   = 5'd19,
    FnRl    = 5'd20,
    FnRr    = 5'd21,
    FnSla   = 5'd22,
    FnSra   = 5'd23,
    FnSwap  = 5'd24,
    FnSrl   = 5'd25,
    FnBit   = 5'd26,
    FnRes   = 5'd27,
    FnSet   = 5'd28,
    FnAdd16 = 5'd29,
    FnAddSp = 5'd30
  } alu_func_e;

  // Flag nibble: bit3 Z, bit2 N, bit1 H, bit0 C
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  typedef struct packed {
    alu_func_e   func;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    flags_t      flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags_out;
  } alu_rsp_t;

  // Decimal adjust constants
  localparam logic [7:0] DaaLoAdj   = 8'h06;
  localparam logic [7:0] DaaHiAdj   = 8'h60;
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;

  // True for operations whose result is a byte with a zero upper half
  function automatic logic is_byte_result(alu_func_e f);
    logic r;
    case (f)
      FnCp, FnScf, FnCcf, FnBit, FnAdd16, FnAddSp: r = 1'b0;
      FnAdd, FnAdc, FnSub, FnSbc, FnAnd, FnXor, FnOr, FnInc, FnDec,
      FnRlca, FnRrca, FnRla, FnRra, FnDaa, FnCpl, FnRlc, FnRrc, FnRl,
      FnRr, FnSla, FnSra, FnSwap, FnSrl, FnRes, FnSet: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/cpualu_if.sv
interface cpualu_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  func;
  logic [15:0] operand_a;
  logic [15:0] operand_b;
  logic [2:0]  bit_index;
  logic [3:0]  flags_in;

  modport source (
    output valid, func, operand_a, operand_b, bit_index, flags_in,
    input  ready
  );
  modport sink (
    input  valid, func, operand_a, operand_b, bit_index, flags_in,
    output ready
  );
endinterface

interface cpualu_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic [3:0]  flags_out;

  modport source (
    output valid, result, flags_out,
    input  ready
  );
  modport sink (
    input  valid, result, flags_out,
    output ready
  );
endinterface

FILE: rtl/cpualu_in_stage.sv
module cpualu_in_stage
  import cpualu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  alu_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output alu_req_t out_req_o
);

  logic     valid_q, valid_d;
  alu_req_t req_q;
  logic     load;

  // Take a new beat whenever the slot is empty or drains this cycle
  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = req_q;

endmodule

FILE: rtl/cpualu_exec.sv
module cpualu_exec
  import cpualu_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [15:0] a16, b16;
  logic [7:0]  a, b;
  flags_t      fi;
  logic        cin, k;
  logic [8:0]  add8, sub8;
  logic [4:0]  add4, sub4;
  logic [16:0] add16;
  logic [12:0] add12;
  logic [15:0] sp_sum;
  logic [4:0]  sp4;
  logic [8:0]  sp8;
  logic        daa_lo, daa_hi;
  logic [7:0]  daa_corr, daa_r;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  logic [15:0] r;
  flags_t      fo;

  assign a16 = req_i.operand_a;
  assign b16 = req_i.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];
  assign fi  = req_i.flags_in;
  assign cin = fi.c;

  // Carry-in only for the with-carry forms
  assign k = ((req_i.func == FnAdc) || (req_i.func == FnSbc)) ? cin : 1'b0;

  // Shared byte adder and subtractor with nibble carries
  assign add8 = {1'b0, a} + {1'b0, b} + {8'h00, k};
  assign add4 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, k};
  assign sub8 = {1'b0, a} - {1'b0, b} - {8'h00, k};
  assign sub4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, k};

  // Word add and stack pointer offset add
  assign add16  = {1'b0, a16} + {1'b0, b16};
  assign add12  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_sum = a16 + {{8{b[7]}}, b};
  assign sp4    = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp8    = {1'b0, a16[7:0]} + {1'b0, b};

  // Decimal adjust correction
  assign daa_lo   = fi.h || (!fi.n && (a[3:0] > DaaLoLimit));
  assign daa_hi   = fi.c || (!fi.n && (a > DaaHiLimit));
  assign daa_corr = (daa_lo ? DaaLoAdj : 8'h00) | (daa_hi ? DaaHiAdj : 8'h00);
  assign daa_r    = fi.n ? (a - daa_corr) : (a + daa_corr);

  assign bit_mask = 8'h01 << req_i.bit_index;

  // Select result and flags by operation
  always_comb begin
    r8 = 8'h00;
    r  = a16;
    fo = fi;
    case (req_i.func)
      FnAdd, FnAdc: begin
        r8 = add8[7:0];
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: add4[4], c: add8[8]};
        r  = {8'h00, r8};
      end
      FnSub, FnSbc, FnCp: begin
        r8 = sub8[7:0];
        fo = '{z: (r8 == 8'h00), n: 1'b1, h: sub4[4], c: sub8[8]};
        r  = (req_i.func == FnCp) ? a16 : {8'h00, r8};
      end
      FnAnd: begin
        r8 = a & b;
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
        r  = {8'h00, r8};
      end
      FnXor: begin
        r8 = a ^ b;
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
        r  = {8'h00, r8};
      end
      FnOr: begin
        r8 = a | b;
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
        r  = {8'h00, r8};
      end
      FnInc: begin
        r8 = a + 8'h01;
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
        r  = {8'h00, r8};
      end
      FnDec: begin
        r8 = a - 8'h01;
        fo = '{z: (r8 == 8'h00), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
        r  = {8'h00, r8};
      end
      FnRlca, FnRlc: begin
        r8 = {a[6:0], a[7]};
        fo = '{z: (req_i.func == FnRlc) && (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
        r  = {8'h00, r8};
      end
      FnRrca, FnRrc: begin
        r8 = {a[0], a[7:1]};
        fo = '{z: (req_i.func == FnRrc) && (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
        r  = {8'h00, r8};
      end
      FnRla, FnRl: begin
        r8 = {a[6:0], cin};
        fo = '{z: (req_i.func == FnRl) && (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
        r  = {8'h00, r8};
      end
      FnRra, FnRr: begin
        r8 = {cin, a[7:1]};
        fo = '{z: (req_i.func == FnRr) && (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
        r  = {8'h00, r8};
      end
      FnDaa: begin
        r8 = daa_r;
        fo = '{z: (r8 == 8'h00), n: fi.n, h: 1'b0, c: daa_hi};
        r  = {8'h00, r8};
      end
      FnCpl: begin
        r8 = ~a;
        fo = '{z: fi.z, n: 1'b1, h: 1'b1, c: cin};
        r  = {8'h00, r8};
      end
      FnScf: begin
        fo = '{z: fi.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      FnCcf: begin
        fo = '{z: fi.z, n: 1'b0, h: 1'b0, c: !cin};
      end
      FnSla: begin
        r8 = {a[6:0], 1'b0};
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
        r  = {8'h00, r8};
      end
      FnSra: begin
        r8 = {a[7], a[7:1]};
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
        r  = {8'h00, r8};
      end
      FnSwap: begin
        r8 = {a[3:0], a[7:4]};
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
        r  = {8'h00, r8};
      end
      FnSrl: begin
        r8 = {1'b0, a[7:1]};
        fo = '{z: (r8 == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
        r  = {8'h00, r8};
      end
      FnBit: begin
        fo = '{z: ((a & bit_mask) == 8'h00), n: 1'b0, h: 1'b1, c: cin};
      end
      FnRes: begin
        r8 = a & ~bit_mask;
        r  = {8'h00, r8};
      end
      FnSet: begin
        r8 = a | bit_mask;
        r  = {8'h00, r8};
      end
      FnAdd16: begin
        r  = add16[15:0];
        fo = '{z: fi.z, n: 1'b0, h: add12[12], c: add16[16]};
      end
      FnAddSp: begin
        r  = sp_sum;
        fo = '{z: 1'b0, n: 1'b0, h: sp4[4], c: sp8[8]};
      end
      default: begin
        r  = a16;
        fo = fi;
      end
    endcase
  end

  assign rsp_o.result    = r;
  assign rsp_o.flags_out = fo;

endmodule

FILE: rtl/cpu_alu_with_flags.sv
// Path: the input beat is held in the input register, then its result in the
//   result register before it is offered as the result beat.
// Throughput: one operation per cycle while not stalled; the result register
//   frees as it drains, so a new beat is taken as the last result is handed over.
// Reset: rst_ni clears both stage valid bits; no clearing pass follows.
module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  cpualu_req_if.sink   req_i,
  cpualu_rsp_if.source rsp_o
);

  alu_req_t in_req;
  alu_req_t s1_req;
  logic     s1_valid;
  logic     s2_ready;
  alu_rsp_t exec_rsp;
  alu_rsp_t rsp_q;
  logic     rsp_valid_q, rsp_valid_d;
  logic     rsp_load;

  // Gather the input beat
  assign in_req.func      = alu_func_e'(req_i.func);
  assign in_req.operand_a = req_i.operand_a;
  assign in_req.operand_b = req_i.operand_b;
  assign in_req.bit_index = req_i.bit_index;
  assign in_req.flags_in  = flags_t'(req_i.flags_in);

  cpualu_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_req_i    (in_req),
    .out_valid_o (s1_valid),
    .out_ready_i (s2_ready),
    .out_req_o   (s1_req)
  );

  cpualu_exec u_exec (
    .req_i (s1_req),
    .rsp_o (exec_rsp)
  );

  // Result register: refill when empty or draining
  assign s2_ready = !rsp_valid_q || rsp_o.ready;
  assign rsp_load = s1_valid && s2_ready;

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (s2_ready) begin
      rsp_valid_d = s1_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q <= exec_rsp;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.result    = rsp_q.result;
  assign rsp_o.flags_out = rsp_q.flags_out;

  // An accepted beat always occupies the input register next cycle
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid)
    else $error("accepted beat lost before input register");

  // A stalled input stage keeps its operation
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid && !s2_ready) |=> (s1_valid && $stable(s1_req)))
    else $error("input stage changed while stalled");

  // A drained result with nothing behind it empties the result register
  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_o.ready && !s1_valid) |=> !rsp_valid_q)
    else $error("result beat repeated");

  // Byte operations leave a zero upper byte
  a_byte_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_load && is_byte_result(s1_req.func)) |=> (rsp_o.result[15:8] == 8'h00))
    else $error("byte operation with nonzero upper byte");

endmodule

FILE: sim/tb.sv
module tb;
  import cpualu_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int TailCycles  = 10;
  localparam logic [4:0] FnUnused = 5'd31;

  // One row of the directed stimulus; rsp is used only when typed is set
  typedef struct {
    alu_req_t req;
    bit       typed;
    alu_rsp_t rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cpualu_req_if req_if ();
  cpualu_rsp_if rsp_if ();

  cpu_alu_with_flags u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  alu_rsp_t pending_rsp_q[$];
  alu_rsp_t next_rsp;
  alu_rsp_t head_rsp;
  dir_row_t dir_rows[$];
  bit       idle_en;
  bit       hold_go;
  int       mismatch_cnt;
  int       beats_in;
  int       beats_out;
  int       holds_done;
  int       op_hits[32];

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Time limit well past the slowest legal run
  initial begin
    #20000000;
    $display("cpu_alu_with_flags regression: fail");
    $finish;
  end

  // Compute the result and flags of one operation
  function automatic alu_rsp_t predict_alu(alu_req_t q);
    alu_rsp_t   p;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r8;
    logic [7:0] corr;
    logic [8:0] s9;
    logic [4:0] s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic       k;
    logic       byte_op;
    flags_t     fi;
    flags_t     fo;
    a       = q.operand_a[7:0];
    b       = q.operand_b[7:0];
    fi      = q.flags_in;
    fo      = fi;
    r8      = a;
    byte_op = 1'b1;
    p.result = q.operand_a;
    case (q.func)
      FnAdd, FnAdc: begin
        k    = (q.func == FnAdc) & fi.c;
        s9   = {1'b0, a} + {1'b0, b} + k;
        s5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + k;
        r8   = s9[7:0];
        fo.z = (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = s5[4];
        fo.c = s9[8];
      end
      FnSub, FnSbc, FnCp: begin
        k    = (q.func == FnSbc) & fi.c;
        r8   = a - b - k;
        fo.z = (r8 == 8'h00);
        fo.n = 1'b1;
        fo.h = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + k);
        fo.c = {1'b0, a} < ({1'b0, b} + k);
        if (q.func == FnCp) byte_op = 1'b0;
      end
      FnAnd, FnXor, FnOr: begin
        if (q.func == FnAnd) r8 = a & b;
        else if (q.func == FnXor) r8 = a ^ b;
        else r8 = a | b;
        fo.z = (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = (q.func == FnAnd);
        fo.c = 1'b0;
      end
      FnInc: begin
        r8   = a + 8'd1;
        fo.z = (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = (a[3:0] == 4'hF);
      end
      FnDec: begin
        r8   = a - 8'd1;
        fo.z = (r8 == 8'h00);
        fo.n = 1'b1;
        fo.h = (a[3:0] == 4'h0);
      end
      FnRlca, FnRlc, FnRla, FnRl, FnSla: begin
        if (q.func == FnRlca || q.func == FnRlc) r8 = {a[6:0], a[7]};
        else if (q.func == FnSla) r8 = {a[6:0], 1'b0};
        else r8 = {a[6:0], fi.c};
        // accumulator rotates always clear Z
        fo.z = (q.func != FnRlca && q.func != FnRla) && (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = 1'b0;
        fo.c = a[7];
      end
      FnRrca, FnRrc, FnRra, FnRr, FnSra, FnSrl: begin
        if (q.func == FnRrca || q.func == FnRrc) r8 = {a[0], a[7:1]};
        else if (q.func == FnSra) r8 = {a[7], a[7:1]};
        else if (q.func == FnSrl) r8 = {1'b0, a[7:1]};
        else r8 = {fi.c, a[7:1]};
        fo.z = (q.func != FnRrca && q.func != FnRra) && (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = 1'b0;
        fo.c = a[0];
      end
      FnDaa: begin
        corr = 8'h00;
        if (fi.h || (!fi.n && a[3:0] > 4'h9)) corr = corr | 8'h06;
        if (fi.c || (!fi.n && a > 8'h99)) begin
          corr = corr | 8'h60;
          fo.c = 1'b1;
        end
        r8   = fi.n ? (a - corr) : (a + corr);
        fo.z = (r8 == 8'h00);
        fo.h = 1'b0;
      end
      FnCpl: begin
        r8   = ~a;
        fo.n = 1'b1;
        fo.h = 1'b1;
      end
      FnScf, FnCcf: begin
        byte_op = 1'b0;
        fo.n = 1'b0;
        fo.h = 1'b0;
        fo.c = (q.func == FnScf) ? 1'b1 : ~fi.c;
      end
      FnSwap: begin
        r8   = {a[3:0], a[7:4]};
        fo.z = (r8 == 8'h00);
        fo.n = 1'b0;
        fo.h = 1'b0;
        fo.c = 1'b0;
      end
      FnBit: begin
        byte_op = 1'b0;
        fo.z = ~a[q.bit_index];
        fo.n = 1'b0;
        fo.h = 1'b1;
      end
      FnRes: r8[q.bit_index] = 1'b0;
      FnSet: r8[q.bit_index] = 1'b1;
      FnAdd16: begin
        byte_op  = 1'b0;
        s17      = {1'b0, q.operand_a} + {1'b0, q.operand_b};
        s13      = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
        p.result = s17[15:0];
        fo.n = 1'b0;
        fo.h = s13[12];
        fo.c = s17[16];
      end
      FnAddSp: begin
        byte_op  = 1'b0;
        p.result = q.operand_a + {{8{b[7]}}, b};
        s5       = {1'b0, q.operand_a[3:0]} + {1'b0, b[3:0]};
        s9       = {1'b0, q.operand_a[7:0]} + {1'b0, b};
        fo.z = 1'b0;
        fo.n = 1'b0;
        fo.h = s5[4];
        fo.c = s9[8];
      end
      default: byte_op = 1'b0;
    endcase
    if (byte_op) p.result = {8'h00, r8};
    p.flags_out = fo;
    return p;
  endfunction

  // Favor byte values at nibble, sign and decimal boundaries
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 15))
      0: v = 8'h00;
      1: v = 8'hFF;
      2: v = 8'h0F;
      3: v = 8'h10;
      4: v = 8'h80;
      5: v = 8'h7F;
      6: v = 8'h99;
      7: v = 8'h9A;
      8: v = 8'h09;
      9: v = 8'h01;
      default: v = 8'($urandom);
    endcase
    return v;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    q.func      = alu_func_e'(5'($urandom_range(0, 31)));
    q.operand_a = $urandom_range(0, 1) ? 16'($urandom) : {8'($urandom), pick_byte()};
    q.operand_b = $urandom_range(0, 1) ? 16'($urandom) : {8'($urandom), pick_byte()};
    q.bit_index = 3'($urandom);
    q.flags_in  = flags_t'(4'($urandom));
    return q;
  endfunction

  task automatic add_row(input logic [4:0] fn, input logic [15:0] a, input logic [15:0] b,
                         input logic [2:0] bi, input logic [3:0] fl, input bit typed,
                         input logic [15:0] res, input logic [3:0] fo);
    dir_row_t row;
    row.req.func          = alu_func_e'(fn);
    row.req.operand_a     = a;
    row.req.operand_b     = b;
    row.req.bit_index     = bi;
    row.req.flags_in      = flags_t'(fl);
    row.typed             = typed;
    row.rsp.result        = res;
    row.rsp.flags_out     = flags_t'(fo);
    dir_rows.push_back(row);
  endtask

  // Offer one beat, hold it until taken, then maybe leave a gap
  task automatic drive_beat(input alu_req_t q, input alu_rsp_t r);
    int n;
    @(negedge clk_i);
    req_if.valid     <= 1'b1;
    req_if.func      <= q.func;
    req_if.operand_a <= q.operand_a;
    req_if.operand_b <= q.operand_b;
    req_if.bit_index <= q.bit_index;
    req_if.flags_in  <= q.flags_in;
    next_rsp = r;
    do @(posedge clk_i); while (!req_if.ready);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      @(negedge clk_i);
      req_if.valid     <= 1'b0;
      req_if.func      <= 5'($urandom);
      req_if.operand_a <= 16'($urandom);
      req_if.operand_b <= 16'($urandom);
      req_if.bit_index <= 3'($urandom);
      req_if.flags_in  <= 4'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait for every pending result
  task automatic drain();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Result side: random stall bursts, plus a long hold on request
  initial begin
    int stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        holds_done++;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        rsp_if.ready <= 1'b0;
        stall = $urandom_range(1, 19) - 1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest pending one, then log new input beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        beats_out++;
        if (pending_rsp_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result beat: result %h flags %b",
                     rsp_if.result, rsp_if.flags_out);
          mismatch_cnt++;
        end else begin
          head_rsp = pending_rsp_q.pop_front();
          if (rsp_if.result !== head_rsp.result || rsp_if.flags_out !== head_rsp.flags_out) begin
            if (mismatch_cnt < 10)
              $display("mismatch at beat %0d: result exp %h got %h, flags exp %b got %b",
                       beats_out, head_rsp.result, rsp_if.result,
                       head_rsp.flags_out, rsp_if.flags_out);
            mismatch_cnt++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_rsp_q.push_back(next_rsp);
        op_hits[req_if.func]++;
        beats_in++;
      end
    end
  end

  // Stimulus
  initial begin
    int ops_covered;
    idle_en          = 1'b1;
    hold_go          = 1'b0;
    req_if.valid     = 1'b0;
    req_if.func      = 5'd0;
    req_if.operand_a = 16'h0000;
    req_if.operand_b = 16'h0000;
    req_if.bit_index = 3'd0;
    req_if.flags_in  = 4'h0;
    rst_ni           = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: carry out and zero, borrows, flag keeping, decimal adjust,
    // ignored upper bytes and the unused code
    add_row(FnAdd,   16'hAAFF, 16'h5501, 3'd0, 4'h0, 1'b1, 16'h0000, 4'b1011);
    add_row(FnAdc,   16'h000F, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0010, 4'b0010);
    add_row(FnSub,   16'hFF00, 16'h0001, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'b0111);
    add_row(FnSbc,   16'h0010, 16'h000F, 3'd0, 4'h1, 1'b1, 16'h0000, 4'b1110);
    add_row(FnAnd,   16'h00F0, 16'h000F, 3'd0, 4'hF, 1'b1, 16'h0000, 4'b1010);
    add_row(FnXor,   16'h00FF, 16'hFFFF, 3'd0, 4'h7, 1'b1, 16'h0000, 4'b1000);
    add_row(FnOr,    16'h0000, 16'h0080, 3'd0, 4'hF, 1'b1, 16'h0080, 4'b0000);
    add_row(FnCp,    16'h1234, 16'h0034, 3'd0, 4'h0, 1'b1, 16'h1234, 4'b1100);
    add_row(FnInc,   16'h00FF, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0000, 4'b1011);
    add_row(FnDec,   16'h0000, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h00FF, 4'b0110);
    add_row(FnRlca,  16'h0080, 16'h0000, 3'd0, 4'h8, 1'b1, 16'h0001, 4'b0001);
    add_row(FnRrca,  16'h0001, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0080, 4'b0001);
    add_row(FnRla,   16'h0080, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'b0001);
    add_row(FnRra,   16'h0001, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0080, 4'b0001);
    add_row(FnDaa,   16'h009A, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'b1001);
    add_row(FnDaa,   16'h0000, 16'h0000, 3'd0, 4'h7, 1'b1, 16'h009A, 4'b0101);
    add_row(FnCpl,   16'h005A, 16'h0000, 3'd0, 4'h9, 1'b1, 16'h00A5, 4'b1111);
    add_row(FnScf,   16'hBEEF, 16'h0000, 3'd0, 4'hE, 1'b1, 16'hBEEF, 4'b1001);
    add_row(FnCcf,   16'h0000, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0000, 4'b0000);
    add_row(FnRlc,   16'hFF00, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'b1000);
    add_row(FnRrc,   16'h00A5, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'b0000);
    add_row(FnRl,    16'h0080, 16'h0000, 3'd0, 4'h0, 1'b1, 16'h0000, 4'b1001);
    add_row(FnRr,    16'h0000, 16'h0000, 3'd0, 4'h1, 1'b1, 16'h0080, 4'b0000);
    add_row(FnSla,   16'h00C3, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'b0000);
    add_row(FnSra,   16'h0081, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'b0000);
    add_row(FnSwap,  16'h12F0, 16'h0000, 3'd0, 4'hF, 1'b0, 16'h0000, 4'b0000);
    add_row(FnSrl,   16'h0001, 16'h0000, 3'd0, 4'h0, 1'b0, 16'h0000, 4'b0000);
    add_row(FnBit,   16'h007F, 16'h0000, 3'd7, 4'h1, 1'b0, 16'h0000, 4'b0000);
    add_row(FnRes,   16'hFFFF, 16'h0000, 3'd0, 4'hA, 1'b0, 16'h0000, 4'b0000);
    add_row(FnSet,   16'h0000, 16'h0000, 3'd7, 4'h5, 1'b0, 16'h0000, 4'b0000);
    add_row(FnAdd16, 16'hFFFF, 16'h0001, 3'd0, 4'h8, 1'b1, 16'h0000, 4'b1011);
    add_row(FnAddSp, 16'hFFF8, 16'h0008, 3'd0, 4'hF, 1'b1, 16'h0000, 4'b0011);
    add_row(FnAddSp, 16'h0000, 16'h00FF, 3'd0, 4'h0, 1'b0, 16'h0000, 4'b0000);
    add_row(FnUnused, 16'hFFFF, 16'hFFFF, 3'd7, 4'hF, 1'b1, 16'hFFFF, 4'b1111);

    foreach (dir_rows[i])
      drive_beat(dir_rows[i].req,
                 dir_rows[i].typed ? dir_rows[i].rsp : predict_alu(dir_rows[i].req));

    // Random beats with idling on both sides
    repeat (700) begin
      alu_req_t q;
      q = rand_req();
      drive_beat(q, predict_alu(q));
    end

    // Hold off the result side while beats keep coming, so the pipe backs up
    hold_go = 1'b1;
    repeat (60) begin
      alu_req_t q;
      q = rand_req();
      drive_beat(q, predict_alu(q));
    end

    // Pause until the pipe is empty
    drain();

    repeat (900) begin
      alu_req_t q;
      q = rand_req();
      drive_beat(q, predict_alu(q));
    end

    // Closing stretch at full rate
    idle_en = 1'b0;
    repeat (240) begin
      alu_req_t q;
      q = rand_req();
      drive_beat(q, predict_alu(q));
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);

    ops_covered = 0;
    foreach (op_hits[i]) if (op_hits[i] != 0) ops_covered++;
    $display("%0d operation beats in, %0d result beats out, %0d of 32 function codes hit",
             beats_in, beats_out, ops_covered);
    $display("%0d long result stall(s) with back-pressure, %0d mismatch(es)",
             holds_done, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("cpu_alu_with_flags regression: pass");
    end else begin
      $display("cpu_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule
